// File: design/tzr_pkg.sv
// Package for the triangle z-buffer rasterizer: screen geometry, commands,
// reset values of the frame store. No dependencies.
`default_nettype none
package tzr_pkg;
   localparam int SCREEN_WIDTH  = 180;
   localparam int SCREEN_HEIGHT = 55;
   localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(PIXEL_COUNT);
   localparam int CELL_W        = 28; // depth 16, color 4, glyph 8

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [15:0] DEPTH_MAX   = 16'hFFFF;
   localparam logic [7:0]  GLYPH_BLANK = 8'd32;
   localparam logic [3:0]  COLOR_BLANK = 4'd8;
   localparam logic [13:0] COUNT_MAX   = 14'h3FFF;
   localparam logic [CELL_W-1:0] CELL_BLANK = {DEPTH_MAX, COLOR_BLANK, GLYPH_BLANK};

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;
endpackage
`default_nettype wire

// File: design/tzr_frame_ram.sv
// Frame store: one synchronous RAM of depth, color and glyph per pixel.
// Depends on tzr_pkg.
`default_nettype none
module tzr_frame_ram (
   input  wire logic                      clock,
   input  wire tzr_pkg::mem_req_type      req,
   output logic [tzr_pkg::CELL_W-1:0]     rdata
);
   import tzr_pkg::*;
   logic [CELL_W-1:0] mem [PIXEL_COUNT];
   always_ff @(posedge clock) begin
      if (req.we) mem[req.waddr] <= req.wdata;
      rdata <= mem[req.raddr];
   end
endmodule
`default_nettype wire

// File: design/triangle_zbuffer_rasterizer.sv
// Triangle z-buffer rasterizer top level: command sequencer, scan and edge test.
// Depends on tzr_pkg and tzr_frame_ram.
//
// Commands are taken while busy is low; each gives one result strobe (rsp_valid)
// that cannot be held off. Reset and a clear command both sweep the frame RAM,
// one pixel per cycle, with busy high. A read passes through ST_READ and ST_READ2.
// A draw first averages the depths (sum times a reciprocal of three, in ST_DIV),
// then walks the clipped bounding box one pixel per cycle through the RAM: each
// pixel is read, its stored depth comes back while the edges are tested, and the
// write lands in stage 2 after the depth test. The scan never visits a pixel twice
// in one draw, so a read never meets a pending write to the same address, and the
// drain empties the pipe before the next transaction. Unused command 3 answers
// with zeros in the next cycle.
`default_nettype none
module triangle_zbuffer_rasterizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic signed [11:0] req_vertex0_x,
   input  wire logic signed [11:0] req_vertex0_y,
   input  wire logic signed [11:0] req_vertex1_x,
   input  wire logic signed [11:0] req_vertex1_y,
   input  wire logic signed [11:0] req_vertex2_x,
   input  wire logic signed [11:0] req_vertex2_y,
   input  wire logic [15:0] req_depth0,
   input  wire logic [15:0] req_depth1,
   input  wire logic [15:0] req_depth2,
   input  wire logic [11:0] req_cell_value,
   input  wire logic [13:0] req_pixel_index,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_glyph,
   output logic [3:0]       rsp_read_color,
   output logic [15:0]      rsp_read_depth,
   output logic [13:0]      rsp_pixels_written
);
   import tzr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_READ2 = 3'd6;

   // ceil(2^19 / 3): exact floor division for sums below 2^19
   localparam logic [17:0] RECIP3 = 18'd174763;

   logic [2:0] state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff;

   // vertex and face registers
   logic signed [12:0] vx_ff [3];
   logic signed [12:0] vy_ff [3];
   logic [17:0] sum_ff;     // depth sum
   logic [15:0] quo_ff;
   logic [35:0] quo_prod;
   logic [11:0] cell_ff;
   logic [13:0] count_ff;
   logic        rd_oob_ff;
   logic [ADDR_W-1:0] rd_addr_ff;

   // scan position and box limits (screen coordinates fit 8 bits)
   logic signed [12:0] lox_ff, hix_ff, hiy_ff, x_ff, y_ff;
   logic        box_empty_ff;

   // pipe stage 1: RAM data back, edges tested; stage 2: depth test and write
   logic              p1_v_ff, p2_v_ff;
   logic [ADDR_W-1:0] p1_a_ff, p2_a_ff;
   logic signed [12:0] p1_x_ff, p1_y_ff;
   logic [2:0]        p2_e_ff;
   logic [15:0]       p2_d_ff; // stored depth of the stage-2 pixel

   mem_req_type       mreq;
   logic [CELL_W-1:0] rdata;

   tzr_frame_ram u_ram (.clock(clock), .req(mreq), .rdata(rdata));

   assign quo_prod = 36'(sum_ff) * 36'(RECIP3);

   // edge products: combinational; the edge test results are registered between stages
   logic signed [25:0] lhs [3], rhs [3];
   logic [2:0] e_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lhs[i] = 26'(p1_y_ff - vy_ff[i]) * 26'(vx_ff[i] - vx_ff[(i+1)%3]);
         rhs[i] = 26'(p1_x_ff - vx_ff[i]) * 26'(vy_ff[i] - vy_ff[(i+1)%3]);
         e_in[i] = lhs[i] >= rhs[i];
      end
   end

   logic [15:0] stored_depth, face_depth;
   logic        wr_hit;
   assign face_depth   = quo_ff;
   assign stored_depth = p2_d_ff;
   assign wr_hit       = p2_v_ff && (&p2_e_ff) && (face_depth < stored_depth);

   // min / max helpers
   function automatic logic signed [12:0] mn(input logic signed [12:0] a, b, c);
      logic signed [12:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction
   function automatic logic signed [12:0] mx(input logic signed [12:0] a, b, c);
      logic signed [12:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   logic last_pix;
   assign last_pix = (x_ff == hix_ff) && (y_ff == hiy_ff);

   always_comb begin
      mreq = '0;
      mreq.raddr = rd_addr_ff;
      if (state_ff == ST_CLEAR) begin
         mreq.we = 1'b1; mreq.waddr = clr_ff; mreq.wdata = CELL_BLANK;
      end else if (wr_hit) begin
         mreq.we = 1'b1; mreq.waddr = p2_a_ff;
         mreq.wdata = {face_depth, cell_ff};
      end
      if (state_ff == ST_SCAN)
         mreq.raddr = ADDR_W'(y_ff * 13'(SCREEN_WIDTH) + x_ff);
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == ADDR_W'(PIXEL_COUNT-1)) state_in = ST_IDLE;
         ST_DIV:   state_in = box_empty_ff ? ST_DRAIN : ST_SCAN;
         ST_SCAN:  if (last_pix) state_in = ST_DRAIN;
         ST_DRAIN: if (!p1_v_ff && !p2_v_ff) state_in = ST_IDLE;
         ST_READ:  state_in = ST_READ2;
         ST_READ2: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= 1'b0;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         // pipe
         p1_v_ff <= (state_ff == ST_SCAN);
         p1_a_ff <= mreq.raddr;
         p1_x_ff <= x_ff;
         p1_y_ff <= y_ff;
         p2_v_ff <= p1_v_ff;
         p2_a_ff <= p1_a_ff;
         p2_e_ff <= e_in;
         p2_d_ff <= rdata[27:12];
         if (wr_hit && count_ff != COUNT_MAX) count_ff <= count_ff + 1'b1;
         if (state_ff == ST_SCAN) begin
            if (x_ff == hix_ff) begin x_ff <= lox_ff; y_ff <= y_ff + 1'b1; end
            else x_ff <= x_ff + 1'b1;
         end
         // floor(sum / 3) by reciprocal multiply
         if (state_ff == ST_DIV) quo_ff <= quo_prod[34:19];
         rsp_read_glyph <= '0; rsp_read_color <= '0; rsp_read_depth <= '0;
         rsp_pixels_written <= '0;
         if (state_ff == ST_DRAIN && state_in == ST_IDLE) begin
            rsp_valid <= 1'b1;
            rsp_pixels_written <= count_ff;
         end
         if (state_ff == ST_READ2) begin
            rsp_valid <= 1'b1;
            if (!rd_oob_ff) begin
               rsp_read_glyph <= rdata[7:0];
               rsp_read_color <= rdata[11:8];
               rsp_read_depth <= rdata[27:12];
            end
         end
         if (start && !busy) begin
            unique case (req_command)
               CMD_CLEAR: begin state_ff <= ST_CLEAR; clr_ff <= '0; rsp_valid <= 1'b1; end
               CMD_DRAW: begin
                  state_ff <= ST_DIV;
                  count_ff <= '0;
                  sum_ff   <= 18'(req_depth0) + 18'(req_depth1) + 18'(req_depth2);
                  cell_ff  <= req_cell_value;
                  vx_ff[0] <= 13'(req_vertex0_x); vy_ff[0] <= 13'(req_vertex0_y);
                  vx_ff[1] <= 13'(req_vertex1_x); vy_ff[1] <= 13'(req_vertex1_y);
                  vx_ff[2] <= 13'(req_vertex2_x); vy_ff[2] <= 13'(req_vertex2_y);
                  begin
                     logic signed [12:0] lx, hx, ly, hy;
                     lx = mn(13'(req_vertex0_x), 13'(req_vertex1_x), 13'(req_vertex2_x));
                     hx = mx(13'(req_vertex0_x), 13'(req_vertex1_x), 13'(req_vertex2_x));
                     ly = mn(13'(req_vertex0_y), 13'(req_vertex1_y), 13'(req_vertex2_y));
                     hy = mx(13'(req_vertex0_y), 13'(req_vertex1_y), 13'(req_vertex2_y));
                     if (lx < 0) lx = '0;
                     if (ly < 0) ly = '0;
                     if (hx > 13'(SCREEN_WIDTH-1))  hx = 13'(SCREEN_WIDTH-1);
                     if (hy > 13'(SCREEN_HEIGHT-1)) hy = 13'(SCREEN_HEIGHT-1);
                     lox_ff <= lx; hix_ff <= hx; hiy_ff <= hy;
                     x_ff <= lx; y_ff <= ly;
                     box_empty_ff <= (lx > hx) || (ly > hy);
                  end
               end
               CMD_READ: begin
                  state_ff   <= ST_READ;
                  rd_oob_ff  <= (req_pixel_index >= 14'(PIXEL_COUNT));
                  rd_addr_ff <= ADDR_W'(req_pixel_index);
               end
               CMD_NOP: rsp_valid <= 1'b1;
               default: rsp_valid <= 1'b1;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// File: dv/tb_triangle_zbuffer_rasterizer.sv
// Testbench for triangle_zbuffer_rasterizer: directed and random clear, draw, read
// and no-op transactions, each result checked against an in-bench frame predictor.
// Depends on tzr_pkg and the design files.
`default_nettype none
module tb_triangle_zbuffer_rasterizer;
   import tzr_pkg::*;

   localparam int STALL_LIMIT = 40000;   // covers a full clearing sweep plus idle gaps
   localparam int DRAIN_LIMIT = 60000;

   typedef struct {
      logic [1:0]         command;
      logic signed [11:0] x0, y0, x1, y1, x2, y2;
      logic [15:0]        d0, d1, d2;
      logic [11:0]        cell_val;
      logic [13:0]        index;
   } face_cmd_type;

   typedef struct {
      logic [7:0]  glyph;
      logic [3:0]  color;
      logic [15:0] depth;
      logic [13:0] written;
   } pixel_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]         req_command = '0;
   logic signed [11:0] req_vertex0_x = '0, req_vertex0_y = '0;
   logic signed [11:0] req_vertex1_x = '0, req_vertex1_y = '0;
   logic signed [11:0] req_vertex2_x = '0, req_vertex2_y = '0;
   logic [15:0] req_depth0 = '0, req_depth1 = '0, req_depth2 = '0;
   logic [11:0] req_cell_value = '0;
   logic [13:0] req_pixel_index = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_glyph;
   logic [3:0]  rsp_read_color;
   logic [15:0] rsp_read_depth;
   logic [13:0] rsp_pixels_written;

   triangle_zbuffer_rasterizer uut (
      .clock, .reset, .start, .busy,
      .req_command, .req_vertex0_x, .req_vertex0_y, .req_vertex1_x, .req_vertex1_y,
      .req_vertex2_x, .req_vertex2_y, .req_depth0, .req_depth1, .req_depth2,
      .req_cell_value, .req_pixel_index,
      .rsp_valid, .rsp_read_glyph, .rsp_read_color, .rsp_read_depth,
      .rsp_pixels_written
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted frame contents
   logic [15:0] frame_depth [PIXEL_COUNT];
   logic [7:0]  frame_glyph [PIXEL_COUNT];
   logic [3:0]  frame_color [PIXEL_COUNT];

   pixel_rsp_type pending_rsp [$];
   int errors = 0;
   int n_sent = 0, n_draws = 0, n_reads = 0, n_clears = 0, n_pixels = 0;
   int idle_pct = 0;
   bit accepted_now = 1'b0;
   int quiet_cycles = 0;

   function automatic void wipe_frame();
      for (int i = 0; i < PIXEL_COUNT; i++) begin
         frame_depth[i] = DEPTH_MAX;
         frame_glyph[i] = GLYPH_BLANK;
         frame_color[i] = COLOR_BLANK;
      end
   endfunction

   function automatic bit edge_pass(longint x, longint y, longint ax, longint ay,
                                    longint bx, longint by);
      return (y - ay) * (ax - bx) >= (x - ax) * (ay - by);
   endfunction

   // Rasterise one face into the predicted frame, returning the pixels written
   function automatic logic [13:0] raster_face(face_cmd_type c);
      longint x0, y0, x1, y1, x2, y2, lx, hx, ly, hy, idx;
      logic [17:0] sum;
      logic [15:0] zf;
      int count;
      x0 = c.x0; y0 = c.y0; x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
      sum = 18'(c.d0) + 18'(c.d1) + 18'(c.d2);
      zf = 16'(sum / 3);
      count = 0;
      lx = x0 < x1 ? x0 : x1; lx = lx < x2 ? lx : x2;
      hx = x0 > x1 ? x0 : x1; hx = hx > x2 ? hx : x2;
      ly = y0 < y1 ? y0 : y1; ly = ly < y2 ? ly : y2;
      hy = y0 > y1 ? y0 : y1; hy = hy > y2 ? hy : y2;
      if (lx < 0) lx = 0;
      if (ly < 0) ly = 0;
      if (hx > SCREEN_WIDTH - 1) hx = SCREEN_WIDTH - 1;
      if (hy > SCREEN_HEIGHT - 1) hy = SCREEN_HEIGHT - 1;
      for (longint y = ly; y <= hy; y++) begin
         for (longint x = lx; x <= hx; x++) begin
            if (edge_pass(x, y, x0, y0, x1, y1) && edge_pass(x, y, x1, y1, x2, y2) &&
                edge_pass(x, y, x2, y2, x0, y0)) begin
               idx = y * SCREEN_WIDTH + x;
               if (zf < frame_depth[idx]) begin
                  frame_depth[idx] = zf;
                  frame_glyph[idx] = c.cell_val[7:0];
                  frame_color[idx] = c.cell_val[11:8];
                  if (count < COUNT_MAX) count++;
               end
            end
         end
      end
      return 14'(count);
   endfunction

   function automatic pixel_rsp_type predict_pixel(face_cmd_type c);
      pixel_rsp_type r;
      r = '{default: '0};
      case (c.command)
         CMD_CLEAR: wipe_frame();
         CMD_DRAW:  r.written = raster_face(c);
         CMD_READ: begin
            if (c.index < PIXEL_COUNT) begin
               r.glyph = frame_glyph[c.index];
               r.color = frame_color[c.index];
               r.depth = frame_depth[c.index];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Present one transaction and hold it until accepted; called at a rising edge.
   // Start stays high on return so back-to-back transactions need no re-raise.
   task automatic send_cmd(face_cmd_type c);
      while (($urandom % 100) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_command   <= c.command;
      req_vertex0_x <= c.x0; req_vertex0_y <= c.y0;
      req_vertex1_x <= c.x1; req_vertex1_y <= c.y1;
      req_vertex2_x <= c.x2; req_vertex2_y <= c.y2;
      req_depth0 <= c.d0; req_depth1 <= c.d1; req_depth2 <= c.d2;
      req_cell_value  <= c.cell_val;
      req_pixel_index <= c.index;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      accepted_now = 1'b1;
      pending_rsp.push_back(predict_pixel(c));
      n_sent++;
      case (c.command)
         CMD_CLEAR: n_clears++;
         CMD_DRAW:  n_draws++;
         CMD_READ:  n_reads++;
         default: ;
      endcase
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic face_cmd_type make_read(logic [13:0] idx);
      face_cmd_type c;
      c = '{default: '0};
      c.command = CMD_READ;
      c.index = idx;
      return c;
   endfunction

   function automatic face_cmd_type make_face(int ax, int ay, int bx, int by, int cx, int cy,
                                              logic [15:0] d0, logic [15:0] d1,
                                              logic [15:0] d2, logic [11:0] cell_val);
      face_cmd_type c;
      c = '{default: '0};
      c.command = CMD_DRAW;
      c.x0 = 12'(ax); c.y0 = 12'(ay); c.x1 = 12'(bx); c.y1 = 12'(by);
      c.x2 = 12'(cx); c.y2 = 12'(cy);
      c.d0 = d0; c.d1 = d1; c.d2 = d2; c.cell_val = cell_val;
      c.index = 14'($urandom);
      return c;
   endfunction

   // Small face somewhere around the screen, random content
   function automatic face_cmd_type rand_small_face();
      int cx, cy;
      cx = $urandom_range(200) - 10;
      cy = $urandom_range(75) - 10;
      return make_face(cx + $urandom_range(24) - 12, cy + $urandom_range(24) - 12,
                       cx + $urandom_range(24) - 12, cy + $urandom_range(24) - 12,
                       cx + $urandom_range(24) - 12, cy + $urandom_range(24) - 12,
                       16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
   endfunction

   task automatic test_blank_frame();
      send_cmd(make_read(14'd0));
      send_cmd(make_read(14'(PIXEL_COUNT - 1)));
      send_cmd(make_read(14'(PIXEL_COUNT)));     // first index past the frame
      send_cmd(make_read(14'h3FFF));
   endtask

   task automatic test_directed_faces();
      face_cmd_type c;
      // big faces at the vertex extremes, both windings
      send_cmd(make_face(-2048, -2048, 2047, -2048, -2048, 2047,
                         16'hFFFF, 16'hFFFF, 16'hFFFE, 12'hFFF));
      send_cmd(make_face(-2048, -2048, -2048, 2047, 2047, -2048,
                         16'hFFFF, 16'hFFFF, 16'hFFFE, 12'hA41));
      // mean depth at maximum never passes the depth test
      send_cmd(make_face(0, 0, 0, 20, 20, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h123));
      send_cmd(make_face(0, 0, 20, 0, 0, 20, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h123));
      send_cmd(make_face(2, 2, 30, 5, 10, 25, 16'd0, 16'd0, 16'd0, 12'h5AA));
      send_cmd(make_face(2, 2, 10, 25, 30, 5, 16'd0, 16'd0, 16'd0, 12'h5AA));
      send_cmd(make_face(9, 9, 9, 9, 9, 9, 16'd3, 16'd3, 16'd4, 12'h07E));  // single point
      send_cmd(make_face(170, 50, 179, 54, 175, 54, 16'd1, 16'd2, 16'd2, 12'hF00));
      // box entirely off screen: to the left, to the right and below
      send_cmd(make_face(-30, 5, -10, 9, -20, 20, 16'd0, 16'd0, 16'd0, 12'h111));
      send_cmd(make_face(200, 5, 220, 9, 210, 20, 16'd0, 16'd0, 16'd0, 12'h111));
      send_cmd(make_face(5, 60, 9, 80, 20, 70, 16'd0, 16'd0, 16'd0, 12'h111));
      send_cmd(make_face(5, 2047, 9, 2047, 2047, 2047, 16'd0, 16'd0, 16'd0, 12'h111));
      send_cmd(make_read(14'd0));
      send_cmd(make_read(14'(2 * SCREEN_WIDTH + 2)));
      send_cmd(make_read(14'(9 * SCREEN_WIDTH + 9)));
      send_cmd(make_read(14'(PIXEL_COUNT - 1)));
      c = '{default: '1};
      c.command = CMD_NOP;
      send_cmd(c);
      c = '{default: '0};
      c.command = CMD_CLEAR;
      send_cmd(c);
      send_cmd(make_read(14'(9 * SCREEN_WIDTH + 9)));
   endtask

   task automatic test_random_mix(int n_items);
      face_cmd_type c;
      int pick;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(999);
         if (pick < 3) begin
            c = '{default: '0};
            c.command = CMD_CLEAR;
            c.cell_val = 12'($urandom);
            send_cmd(c);
         end else if (pick < 20) begin
            // full-range vertices: box mostly clipped to the whole screen
            c = make_face($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
            send_cmd(c);
         end else if (pick < 560) begin
            send_cmd(rand_small_face());
         end else if (pick < 600) begin
            c = '{default: '0};
            c.command = CMD_NOP;
            c.index = 14'($urandom);
            c.x0 = 12'($urandom); c.d0 = 16'($urandom); c.cell_val = 12'($urandom);
            send_cmd(c);
         end else if (pick < 650) begin
            send_cmd(make_read(14'($urandom)));
         end else begin
            send_cmd(make_read(14'($urandom_range(PIXEL_COUNT - 1))));
         end
      end
   endtask

   // Result checker: the receiver cannot stall, so every strobe is a transaction
   always @(posedge clock) begin
      pixel_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result glyph=%0d color=%0d depth=%0d written=%0d",
                     $time, rsp_read_glyph, rsp_read_color, rsp_read_depth,
                     rsp_pixels_written);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_read_glyph !== want.glyph) begin
               $display("%0t: read_glyph expected %0d actual %0d",
                        $time, want.glyph, rsp_read_glyph);
               errors++;
            end
            if (rsp_read_color !== want.color) begin
               $display("%0t: read_color expected %0d actual %0d",
                        $time, want.color, rsp_read_color);
               errors++;
            end
            if (rsp_read_depth !== want.depth) begin
               $display("%0t: read_depth expected %0d actual %0d",
                        $time, want.depth, rsp_read_depth);
               errors++;
            end
            if (rsp_pixels_written !== want.written) begin
               $display("%0t: pixels_written expected %0d actual %0d",
                        $time, want.written, rsp_pixels_written);
               errors++;
            end
            n_pixels += want.written;
         end
      end
   end

   // Watchdog: cycles with no transaction either way
   always @(posedge clock) begin
      #1;
      if (accepted_now || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      accepted_now = 1'b0;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $time, pending_rsp.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int phase_idle [4] = '{0, 69, 0, 20};
      int drain;
      wipe_frame();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_blank_frame();
      test_directed_faces();
      hold_until_drained();
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         test_random_mix(400);
         if (p == 1) hold_until_drained();
      end
      start <= 1'b0;
      drain = 0;
      while (pending_rsp.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (40) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_rsp.size());
         errors++;
      end
      $display("Sent %0d transactions: %0d draws, %0d reads, %0d clears; %0d pixels drawn.",
               n_sent, n_draws, n_reads, n_clears, n_pixels);
      $display("Idle phases 0/69/0/20 percent on the sender; %0d mismatches.", errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
design/tzr_pkg.sv
design/tzr_frame_ram.sv
design/triangle_zbuffer_rasterizer.sv
dv/tb_triangle_zbuffer_rasterizer.sv
